[hdl/qwt_pkg.sv]
`default_nettype none
package qwt_pkg;

  // lexer phase codes
  localparam logic [2:0] PH_SKIP  = 3'd0;
  localparam logic [2:0] PH_WORD  = 3'd1;
  localparam logic [2:0] PH_BSL   = 3'd2;
  localparam logic [2:0] PH_QUOTE = 3'd3;
  localparam logic [2:0] PH_QBSL  = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_WORD_END = 2'd1;
  localparam logic [1:0] KIND_LINE_END = 2'd2;

  // lexing modes
  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_ESCAPE = 2'd1;
  localparam logic [1:0] MODE_QUOTE  = 2'd2;

  // characters of interest
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_VT     = 8'h0B;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;
  } out_item_t;

  // what one input byte produces: up to two results
  typedef struct packed {
    logic [1:0] count;
    out_item_t  res0;
    out_item_t  res1;
  } step_res_t;

endpackage
`default_nettype wire

[hdl/qwt_step.sv]
`default_nettype none
module qwt_step (
  input  wire qwt_pkg::in_item_t  item,
  input  wire logic [1:0]         lex_mode,
  input  wire logic [2:0]         phase,
  input  wire logic               halted,
  output qwt_pkg::step_res_t      res,
  output logic [2:0]              phase_next,
  output logic                    halted_next
);

  logic       esc_on;
  logic       quote_on;
  logic [7:0] c;
  logic       is_sep;
  logic       is_eol;
  logic [2:0] ph;
  logic [2:0] work;

  // character classes and mode decode
  always_comb begin
    c        = item.in_byte;
    esc_on   = (lex_mode != qwt_pkg::MODE_PLAIN);
    quote_on = lex_mode[1];
    is_sep   = (c == qwt_pkg::CH_SPACE) || (c == qwt_pkg::CH_TAB) ||
               (c == qwt_pkg::CH_FF) || (c == qwt_pkg::CH_VT);
    is_eol   = (c == qwt_pkg::CH_LF) || (c == qwt_pkg::CH_CR);
    ph       = (phase > qwt_pkg::PH_QBSL) ? qwt_pkg::PH_SKIP : phase;
  end

  // phase transition and result generation
  always_comb begin
    res         = '0;
    phase_next  = ph;
    halted_next = halted;
    work        = qwt_pkg::PH_SKIP;
    if (halted) begin
      // line already ended: drop bytes until end of input re-arms
      if (item.is_end) begin
        halted_next = 1'b0;
        phase_next  = qwt_pkg::PH_SKIP;
      end
    end else if (item.is_end) begin
      phase_next = qwt_pkg::PH_SKIP;
      if (ph != qwt_pkg::PH_SKIP) begin
        res.count     = 2'd2;
        res.res0.kind = qwt_pkg::KIND_WORD_END;
        res.res1.kind = qwt_pkg::KIND_LINE_END;
      end else begin
        res.count     = 2'd1;
        res.res0.kind = qwt_pkg::KIND_LINE_END;
      end
    end else begin
      work = ph;
      if (ph == qwt_pkg::PH_SKIP) begin
        if (is_eol) begin
          res.count     = 2'd1;
          res.res0.kind = qwt_pkg::KIND_LINE_END;
          halted_next   = 1'b1;
        end else if (!is_sep) begin
          work       = qwt_pkg::PH_WORD;
          phase_next = qwt_pkg::PH_WORD;
        end
      end
      case (work)
        qwt_pkg::PH_WORD: begin
          if (esc_on && c == qwt_pkg::CH_BSLASH) begin
            phase_next = qwt_pkg::PH_BSL;
          end else if (quote_on && c == qwt_pkg::CH_DQUOTE) begin
            phase_next = qwt_pkg::PH_QUOTE;
          end else if (is_eol) begin
            res.count     = 2'd2;
            res.res0.kind = qwt_pkg::KIND_WORD_END;
            res.res1.kind = qwt_pkg::KIND_LINE_END;
            phase_next    = qwt_pkg::PH_SKIP;
            halted_next   = 1'b1;
          end else if (is_sep) begin
            res.count     = 2'd1;
            res.res0.kind = qwt_pkg::KIND_WORD_END;
            phase_next    = qwt_pkg::PH_SKIP;
          end else begin
            res.count         = 2'd1;
            res.res0.out_byte = c;
          end
        end
        qwt_pkg::PH_BSL: begin
          if (is_eol) begin
            // trailing backslash is dropped
            res.count     = 2'd2;
            res.res0.kind = qwt_pkg::KIND_WORD_END;
            res.res1.kind = qwt_pkg::KIND_LINE_END;
            phase_next    = qwt_pkg::PH_SKIP;
            halted_next   = 1'b1;
          end else begin
            res.count         = 2'd1;
            res.res0.out_byte = c;
            phase_next        = qwt_pkg::PH_WORD;
          end
        end
        qwt_pkg::PH_QUOTE: begin
          if (c == qwt_pkg::CH_BSLASH) begin
            phase_next = qwt_pkg::PH_QBSL;
          end else if (c == qwt_pkg::CH_DQUOTE) begin
            phase_next = qwt_pkg::PH_WORD;
          end else if (is_eol) begin
            res.count     = 2'd2;
            res.res0.kind = qwt_pkg::KIND_WORD_END;
            res.res1.kind = qwt_pkg::KIND_LINE_END;
            phase_next    = qwt_pkg::PH_SKIP;
            halted_next   = 1'b1;
          end else begin
            res.count         = 2'd1;
            res.res0.out_byte = c;
          end
        end
        qwt_pkg::PH_QBSL: begin
          if (is_eol) begin
            res.count     = 2'd2;
            res.res0.kind = qwt_pkg::KIND_WORD_END;
            res.res1.kind = qwt_pkg::KIND_LINE_END;
            phase_next    = qwt_pkg::PH_SKIP;
            halted_next   = 1'b1;
          end else if (c != qwt_pkg::CH_BSLASH && c != qwt_pkg::CH_DQUOTE) begin
            // unknown escape inside quotes keeps the backslash
            res.count         = 2'd2;
            res.res0.out_byte = qwt_pkg::CH_BSLASH;
            res.res1.out_byte = c;
            phase_next        = qwt_pkg::PH_QUOTE;
          end else begin
            res.count         = 2'd1;
            res.res0.out_byte = c;
            phase_next        = qwt_pkg::PH_QUOTE;
          end
        end
        default: begin
        end
      endcase
    end
    // mark the final result of this byte
    if (res.count == 2'd2) begin
      res.res1.last = 1'b1;
    end else if (res.count == 2'd1) begin
      res.res0.last = 1'b1;
    end
  end

endmodule
`default_nettype wire

[hdl/qwt_outq.sv]
`default_nettype none
module qwt_outq (
  input  wire                     clk,
  input  wire                     rst,
  input  wire qwt_pkg::step_res_t push,
  input  wire logic               push_en,
  output logic                    room,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output qwt_pkg::out_item_t      out_item
);

  qwt_pkg::out_item_t mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [1:0] push_n;
  logic       pop;
  logic [1:0] wr_ptr_next;

  // room for a two-result byte; valid from fill level only
  assign room      = (count < 3'd3);
  assign out_valid = (count != 3'd0);
  assign out_item  = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  assign push_n    = push_en ? push.count : 2'd0;
  assign wr_ptr_next = wr_ptr + 2'd1;

  // result storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push.res0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_next] <= push.res1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push_n} - {2'b00, pop};
    end
  end

endmodule
`default_nettype wire

[hdl/quoted_word_tokenizer_core.sv]
`default_nettype none
// Shell-style word splitter: one byte per input transfer, results are word bytes,
// word-end and line-end marks in order, one result transfer per cycle unless
// stalled. A byte is taken every cycle while the four-entry result queue has
// room for two results, so unstalled, bytes giving at most one result stream at
// one per cycle; a byte giving two (line end in a word, unknown escape in quotes)
// queues both. The user must write lex_mode through the cfg channel (always ready)
// only while the block is idle; the block does not enforce this. After a newline
// or carriage return the rest of the line is ignored until an end transfer.
module quoted_word_tokenizer_core (
  input  wire                      clk,
  input  wire                      rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire qwt_pkg::in_item_t   in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output qwt_pkg::out_item_t       out_item,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_data
);

  logic [1:0]         lex_mode;
  logic [2:0]         phase;
  logic               halted;
  logic [2:0]         phase_next;
  logic               halted_next;
  logic               room;
  logic               accept;
  qwt_pkg::step_res_t step;

  assign cfg_ready = 1'b1;
  assign in_stall  = !room;
  assign accept    = in_valid && room;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode <= qwt_pkg::MODE_PLAIN;
    end else if (cfg_valid && cfg_ready) begin
      lex_mode <= cfg_data;
    end
  end

  // lexer state, advanced on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= qwt_pkg::PH_SKIP;
      halted <= 1'b0;
    end else if (accept) begin
      phase  <= phase_next;
      halted <= halted_next;
    end
  end

  qwt_step u_step (
    .item        (in_item),
    .lex_mode    (lex_mode),
    .phase       (phase),
    .halted      (halted),
    .res         (step),
    .phase_next  (phase_next),
    .halted_next (halted_next)
  );

  qwt_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_en   (accept),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

[hdl/qwt_checker.sv]
`default_nettype none
module qwt_checker (
  input wire                     clk,
  input wire                     rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire qwt_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire qwt_pkg::out_item_t out_item
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // marks carry no byte
  a_mark_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind != qwt_pkg::KIND_BYTE |-> out_item.out_byte == 8'd0)
    else $error("mark result with nonzero byte");

  // line end is always the final result of its byte
  a_line_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == qwt_pkg::KIND_LINE_END |-> out_item.last)
    else $error("line end without last");

  // a word end that is not last is followed by the line end
  a_word_end_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_item.kind == qwt_pkg::KIND_WORD_END && !out_item.last
    |=> out_valid && out_item.kind == qwt_pkg::KIND_LINE_END)
    else $error("word end not followed by line end");

  // a stalled input transfer holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input changed");

endmodule

bind quoted_word_tokenizer_core qwt_checker u_qwt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
`default_nettype wire

[tb/sv/tb_quoted_word_tokenizer_core.sv]
`default_nettype none
module tb_quoted_word_tokenizer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 80;
  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 100;
  localparam int NUM_PHASES   = 8;

  // mode code 3 is unused and acts as the quote mode
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] PHASE_MODES [NUM_PHASES] = '{
    qwt_pkg::MODE_QUOTE, qwt_pkg::MODE_PLAIN, qwt_pkg::MODE_ESCAPE, MODE_UNUSED,
    qwt_pkg::MODE_QUOTE, qwt_pkg::MODE_ESCAPE, qwt_pkg::MODE_PLAIN, qwt_pkg::MODE_QUOTE
  };

  // plain mode: byte extremes, the tab, form feed and vertical tab separators, backslash taken literally
  localparam logic [7:0] DIR_PLAIN [6] = '{8'h00, qwt_pkg::CH_TAB, 8'hFF, qwt_pkg::CH_FF,
                                           qwt_pkg::CH_BSLASH, qwt_pkg::CH_VT};
  // escape mode: escaped space, backslash dropped at line end, a byte after the line end
  localparam logic [7:0] DIR_ESCAPE [6] = '{8'h61, qwt_pkg::CH_BSLASH, qwt_pkg::CH_SPACE,
                                            qwt_pkg::CH_BSLASH, qwt_pkg::CH_LF, 8'h78};
  // quote mode: empty quotes, unknown escape kept, escaped quote, tab and cr in quotes
  localparam logic [7:0] DIR_QUOTE [10] = '{qwt_pkg::CH_DQUOTE, qwt_pkg::CH_DQUOTE,
                                            qwt_pkg::CH_SPACE, qwt_pkg::CH_DQUOTE,
                                            qwt_pkg::CH_BSLASH, 8'h6E, qwt_pkg::CH_BSLASH,
                                            qwt_pkg::CH_DQUOTE, qwt_pkg::CH_TAB,
                                            qwt_pkg::CH_CR};

  localparam logic [7:0] SEPS [4] = '{qwt_pkg::CH_SPACE, qwt_pkg::CH_TAB, qwt_pkg::CH_FF,
                                      qwt_pkg::CH_VT};

  // tokenizer predictor and store of expected tokens
  class token_scoreboard;
    logic [1:0]         mode;
    logic [2:0]         phase;
    logic               halted;
    qwt_pkg::out_item_t tokens[$];
    qwt_pkg::out_item_t step_q[$];
    int                 errors;

    function new();
      mode   = qwt_pkg::MODE_PLAIN;
      phase  = qwt_pkg::PH_SKIP;
      halted = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return tokens.size();
    endfunction

    function bit is_sep(logic [7:0] c);
      return c == qwt_pkg::CH_SPACE || c == qwt_pkg::CH_TAB || c == qwt_pkg::CH_FF ||
             c == qwt_pkg::CH_VT;
    endfunction

    function bit is_eol(logic [7:0] c);
      return c == qwt_pkg::CH_LF || c == qwt_pkg::CH_CR;
    endfunction

    function void emit(logic [7:0] b, logic [1:0] k);
      qwt_pkg::out_item_t t;
      t.out_byte = (k == qwt_pkg::KIND_BYTE) ? b : 8'h00;
      t.kind     = k;
      t.last     = 1'b0;
      step_q.push_back(t);
    endfunction

    function void close_line(bit word_open);
      if (word_open) emit(8'h00, qwt_pkg::KIND_WORD_END);
      emit(8'h00, qwt_pkg::KIND_LINE_END);
      phase = qwt_pkg::PH_SKIP;
    endfunction

    // note an accepted byte transfer and queue the tokens it gives
    function void lex_item(qwt_pkg::in_item_t it);
      logic [7:0] c;
      bit         esc_on;
      bit         quote_on;
      c        = it.in_byte;
      esc_on   = (mode != qwt_pkg::MODE_PLAIN);
      quote_on = (mode >= qwt_pkg::MODE_QUOTE);
      step_q.delete();

      // rest of a halted line is dropped until the end transfer
      if (halted) begin
        if (it.is_end) begin
          halted = 1'b0;
          phase  = qwt_pkg::PH_SKIP;
        end
        return;
      end

      if (phase > qwt_pkg::PH_QBSL) phase = qwt_pkg::PH_SKIP;

      if (it.is_end) begin
        close_line(phase != qwt_pkg::PH_SKIP);
      end else begin
        if (phase == qwt_pkg::PH_SKIP) begin
          if (is_eol(c)) begin
            close_line(1'b0);
            halted = 1'b1;
          end else if (!is_sep(c)) begin
            phase = qwt_pkg::PH_WORD;
          end
        end

        case (phase)
          qwt_pkg::PH_WORD: begin
            if (esc_on && c == qwt_pkg::CH_BSLASH) begin
              phase = qwt_pkg::PH_BSL;
            end else if (quote_on && c == qwt_pkg::CH_DQUOTE) begin
              phase = qwt_pkg::PH_QUOTE;
            end else if (is_eol(c)) begin
              close_line(1'b1);
              halted = 1'b1;
            end else if (is_sep(c)) begin
              emit(8'h00, qwt_pkg::KIND_WORD_END);
              phase = qwt_pkg::PH_SKIP;
            end else begin
              emit(c, qwt_pkg::KIND_BYTE);
            end
          end
          qwt_pkg::PH_BSL: begin
            if (is_eol(c)) begin
              close_line(1'b1);
              halted = 1'b1;
            end else begin
              emit(c, qwt_pkg::KIND_BYTE);
              phase = qwt_pkg::PH_WORD;
            end
          end
          qwt_pkg::PH_QUOTE: begin
            if (c == qwt_pkg::CH_BSLASH) begin
              phase = qwt_pkg::PH_QBSL;
            end else if (c == qwt_pkg::CH_DQUOTE) begin
              phase = qwt_pkg::PH_WORD;
            end else if (is_eol(c)) begin
              close_line(1'b1);
              halted = 1'b1;
            end else begin
              emit(c, qwt_pkg::KIND_BYTE);
            end
          end
          qwt_pkg::PH_QBSL: begin
            if (is_eol(c)) begin
              close_line(1'b1);
              halted = 1'b1;
            end else begin
              if (c != qwt_pkg::CH_BSLASH && c != qwt_pkg::CH_DQUOTE) begin
                emit(qwt_pkg::CH_BSLASH, qwt_pkg::KIND_BYTE);
              end
              emit(c, qwt_pkg::KIND_BYTE);
              phase = qwt_pkg::PH_QUOTE;
            end
          end
          default: ;
        endcase
      end

      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) tokens.push_back(step_q[i]);
    endfunction

    // compare an accepted token with the oldest expected one
    function void check_token(qwt_pkg::out_item_t got);
      qwt_pkg::out_item_t want;
      if (tokens.size() == 0) begin
        errors++;
        $display("%0t: unexpected token, expected none, got byte %02h kind %0d last %0b",
                 $time, got.out_byte, got.kind, got.last);
        return;
      end
      want = tokens.pop_front();
      if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
          got.last !== want.last) begin
        errors++;
        $display("%0t: token mismatch, expected byte %02h kind %0d last %0b",
                 $time, want.out_byte, want.kind, want.last,
                 ", got byte %02h kind %0d last %0b",
                 got.out_byte, got.kind, got.last);
      end
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  qwt_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  qwt_pkg::out_item_t out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_data  = '0;

  token_scoreboard sb;
  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  bit rx_hold_req   = 1'b0;
  int rx_hold_left  = 0;
  int items_sent    = 0;
  int quiet_cycles  = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  quoted_word_tokenizer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // transfer monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.lex_item(in_item);
      if (out_valid && !out_stall) sb.check_token(out_item);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_quoted_word_tokenizer_core failed");
        $finish;
      end
    end
  end

  // receiver: random stall, or a long hold on request
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = HOLD_CYCLES;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // offer one item and wait for its transfer
  task automatic put_item(input logic [7:0] b, input logic e, input bit counted);
    qwt_pkg::in_item_t it;
    it.in_byte = b;
    it.is_end  = e;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    if (counted) items_sent++;
  endtask

  // drop valid and let all expected tokens drain
  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    sb.mode = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one random line: mostly words with separators, quotes and escapes, some raw noise
  task automatic send_line();
    int         r;
    logic [7:0] b;
    r = $urandom_range(99);
    if (r < 10) begin
      repeat ($urandom_range(1, 12)) put_item(8'($urandom), 1'b0, 1'b1);
    end else begin
      repeat ($urandom_range(0, 4)) begin
        repeat ($urandom_range(0, 2)) put_item(SEPS[$urandom_range(3)], 1'b0, 1'b1);
        repeat ($urandom_range(1, 6)) begin
          r = $urandom_range(99);
          if (r < 55) b = 8'($urandom_range(8'h21, 8'h7E));
          else if (r < 67) b = qwt_pkg::CH_BSLASH;
          else if (r < 79) b = qwt_pkg::CH_DQUOTE;
          else if (r < 87) b = SEPS[$urandom_range(3)];
          else b = 8'($urandom);
          put_item(b, 1'b0, 1'b1);
        end
      end
      if ($urandom_range(3) == 0) put_item(SEPS[$urandom_range(3)], 1'b0, 1'b1);
    end

    // line terminator, with ignored bytes after a newline or cr
    r = $urandom_range(99);
    if (r < 45) begin
      put_item($urandom_range(1) ? qwt_pkg::CH_LF : qwt_pkg::CH_CR, 1'b0, 1'b1);
      repeat ($urandom_range(0, 3)) put_item(8'($urandom), 1'b0, 1'b0);
      put_item(8'($urandom), 1'b1, 1'b1);
    end else if (r < 90) begin
      put_item(8'($urandom), 1'b1, 1'b1);
    end
  endtask

  initial begin
    int start;
    sb = new();
    tx_idle_pct = 20;
    rx_idle_pct = 83;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed lines
    write_mode(qwt_pkg::MODE_PLAIN);
    for (int i = 0; i < 6; i++) put_item(DIR_PLAIN[i], 1'b0, 1'b1);
    put_item(8'hFF, 1'b1, 1'b1);
    wait_quiet();
    write_mode(qwt_pkg::MODE_ESCAPE);
    for (int i = 0; i < 6; i++) put_item(DIR_ESCAPE[i], 1'b0, 1'b1);
    put_item(8'h00, 1'b1, 1'b1);
    wait_quiet();
    write_mode(MODE_UNUSED);
    for (int i = 0; i < 10; i++) put_item(DIR_QUOTE[i], 1'b0, 1'b1);
    put_item(8'h00, 1'b1, 1'b1);

    // random lines, one mode per phase, words may stay open across mode changes
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_quiet();
      if (p == 3) begin
        tx_idle_pct = 83;
        rx_idle_pct = 20;
      end
      if (p == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 1'b1;
      end
      write_mode(PHASE_MODES[p]);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_line();
    end

    wait_quiet();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_quoted_word_tokenizer_core passed");
    end else begin
      $display("tb_quoted_word_tokenizer_core failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
hdl/qwt_pkg.sv
hdl/qwt_step.sv
hdl/qwt_outq.sv
hdl/quoted_word_tokenizer_core.sv
hdl/qwt_checker.sv
tb/sv/tb_quoted_word_tokenizer_core.sv
